FILE: src/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: text console writer shared definitions
// Screen geometry, command codes passed from front to back, colour names.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // geometry
   localparam int COLUMNS  = 80;
   localparam int ROWS     = 25;
   localparam int NAME_MAX = 14;
   localparam int CELLS    = ROWS * COLUMNS;

   localparam int COL_W = $clog2(COLUMNS);
   localparam int ROW_W = $clog2(ROWS);
   localparam int AW    = $clog2(CELLS);
   localparam int SW    = $clog2(CELLS + 1);
   localparam int NL_W  = $clog2(NAME_MAX + 1);
   localparam int NI_W  = $clog2(NAME_MAX);
   localparam int QDEPTH = 2;
   localparam int QP_W   = $clog2(QDEPTH);
   localparam int QC_W   = $clog2(QDEPTH + 1);

   // port field widths
   localparam int CHAR_W   = 8;
   localparam int CADDR_W  = 11;
   localparam int PCOL_W   = 7;
   localparam int PROW_W   = 5;
   localparam int DATA_W   = 16;
   localparam int CLR_W    = 4;

   // characters and cell values
   localparam logic [7:0]  CH_DOLLAR = 8'h24;
   localparam logic [7:0]  CH_BANG   = 8'h21;
   localparam logic [7:0]  CH_NL     = 8'h0A;
   localparam logic [3:0]  GREY      = 4'd7;
   localparam logic [15:0] FILL_CELL = 16'h0720;

   // request modes
   typedef enum logic [1:0] {
      MODE_WRITE  = 2'd0,
      MODE_READ   = 2'd1,
      MODE_CLEAR  = 2'd2,
      MODE_CURSOR = 2'd3
   } mode_type;

   // classified commands from front to back
   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_CHAR,
      CMD_NL,
      CMD_READ,
      CMD_CLEAR,
      CMD_SETCUR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type             kind;
      logic [CHAR_W-1:0]        char_byte;
      logic [CLR_W-1:0]         color;
      logic [CADDR_W-1:0]       addr;
      logic [COL_W-1:0]         col;
      logic [ROW_W-1:0]         row;
   } cmd_type;

   // colour names, right-justified string literals
   localparam logic [16*8-1:0] NAMES [16] = '{
      "BLACK", "BLUE", "GREEN", "CYAN", "RED", "MAGENTA", "BROWN",
      {"LIGHT_", "GREY"}, {"DARK_", "GREY"}, {"LIGHT_", "BLUE"},
      {"LIGHT_", "GREEN"}, {"LIGHT_", "CYAN"}, {"LIGHT_", "RED"},
      {"LIGHT_", "MAGENTA"}, {"LIGHT_", "BROWN"}, "WHITE"
   };
   localparam int NAME_LEN [16] = '{5, 4, 5, 4, 3, 7, 5, 10, 9, 10, 11, 10,
                                    9, 13, 11, 5};

   // character j of colour name k (j below its length)
   function automatic logic [7:0] name_char(input int k, input int j);
      int pos;
      pos = (NAME_LEN[k] - 1 - j) * 8;
      return NAMES[k][pos +: 8];
   endfunction

endpackage

FILE: src/text_console_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_writer_top: character-cell console engine
// Front classifier and escape parser, command queue, executor with screen RAM.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | contents
//  req     | in  | req_tvalid/tready    | tuser mode, tdata byte/start/addr/cursor
//  rsp     | out | rsp_tvalid/tready    | tdata read data, cursor, scroll, colour
//
//  After reset the screen RAM is filled with grey spaces, one cell a cycle;
//  up to two requests queue meanwhile, none is executed.
//  Executor: a plain byte, set cursor or ignored byte completes on taking
//  the command. A cell read waits for the registered RAM read. Clear zeroes
//  every cell in turn. A byte or newline that moves down steps one row per
//  ST_STEP visit and then finishes; a step off the last row adds a scroll,
//  one cell copied per cycle through the single RAM write port.
//  A waiting response stalls the executor; the two-entry queue keeps
//  taking requests until it is full.
// ----------------------------------------------------------------------------
module text_console_writer_top import tcw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] mode
   input  logic [31:0] req_tdata,   // char_byte, string_start, cell_address,
                                    // new_col, new_row
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // read_data, cursor_col, cursor_row,
                                    // scrolled, active_color, zero pad
);

   logic          req_fire;
   logic          q_full, q_empty, pop;
   cmd_type       cmd, head;
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [DATA_W-1:0] ram_wdata, ram_rdata;
   logic [DATA_W-1:0] rd;
   logic [PCOL_W-1:0] ocol;
   logic [PROW_W-1:0] orow;
   logic              oscr;
   logic [CLR_W-1:0]  oclr;

   assign req_tready = !q_full;
   assign req_fire   = req_tvalid && !q_full;

   tcw_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_fire     (req_fire),
      .mode         (req_tuser),
      .char_byte    (req_tdata[7:0]),
      .string_start (req_tdata[8]),
      .cell_address (req_tdata[19:9]),
      .new_col      (req_tdata[26:20]),
      .new_row      (req_tdata[31:27]),
      .cmd          (cmd)
   );

   tcw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_fire),
      .push_cmd (cmd),
      .pop      (pop),
      .head     (head),
      .full     (q_full),
      .empty    (q_empty)
   );

   tcw_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   tcw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_empty        (q_empty),
      .pop            (pop),
      .ram_we         (ram_we),
      .ram_waddr      (ram_waddr),
      .ram_wdata      (ram_wdata),
      .ram_raddr      (ram_raddr),
      .ram_rdata      (ram_rdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_read_data  (rd),
      .rsp_cursor_col (ocol),
      .rsp_cursor_row (orow),
      .rsp_scrolled   (oscr),
      .rsp_color      (oclr)
   );

   assign rsp_tdata = {7'b0, oclr, oscr, orow, ocol, rd};

endmodule

FILE: src/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front: request classifier
// Runs the colour escape parser and turns each request into one command.
// ----------------------------------------------------------------------------
module tcw_front import tcw_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   input  logic [1:0]           mode,
   input  logic [CHAR_W-1:0]    char_byte,
   input  logic                 string_start,
   input  logic [CADDR_W-1:0]   cell_address,
   input  logic [PCOL_W-1:0]    new_col,
   input  logic [PROW_W-1:0]    new_row,
   output cmd_type              cmd
);

   logic [CLR_W-1:0]  color_ff, color_in;
   logic              esc_ff, esc_in;
   logic              lit_ff, lit_in;
   logic [NL_W-1:0]   len_ff, len_in;
   logic              ovf_ff, ovf_in;
   logic [7:0]        name_ff [NAME_MAX];
   logic              store;
   logic              hit;
   logic [CLR_W-1:0]  hit_code;
   logic              same;

   // colour name lookup
   always_comb begin
      hit      = 1'b0;
      hit_code = '0;
      same     = 1'b0;
      for (int k = 15; k >= 0; k--) begin
         same = (32'(len_ff) == NAME_LEN[k]);
         for (int j = 0; j < NAME_MAX; j++) begin
            if (j < NAME_LEN[k]) begin
               if (name_ff[j] != name_char(k, j)) begin
                  same = 1'b0;
               end
            end
         end
         if (same) begin
            hit      = 1'b1;
            hit_code = CLR_W'(k);
         end
      end
   end

   // classify
   always_comb begin
      color_in  = color_ff;
      esc_in    = esc_ff;
      lit_in    = lit_ff;
      len_in    = len_ff;
      ovf_in    = ovf_ff;
      store     = 1'b0;
      cmd       = '0;
      cmd.kind  = CMD_NOP;
      cmd.addr  = cell_address;
      cmd.char_byte = char_byte;

      unique case (mode_type'(mode))
         MODE_WRITE: begin
            if (string_start) begin
               color_in = GREY;
               esc_in   = 1'b0;
               lit_in   = 1'b0;
            end
            if (char_byte == '0) begin
               cmd.kind = CMD_NOP;
            end else if (lit_in) begin
               lit_in   = 1'b0;
               cmd.kind = (char_byte == CH_NL) ? CMD_NL : CMD_CHAR;
            end else if (esc_in) begin
               if (char_byte == CH_BANG) begin
                  esc_in = 1'b0;
                  lit_in = 1'b1;
                  if (!ovf_ff && hit) begin
                     color_in = hit_code;
                  end
               end else if (32'(len_ff) < NAME_MAX) begin
                  store  = 1'b1;
                  len_in = len_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
            end else if (char_byte == CH_DOLLAR) begin
               esc_in = 1'b1;
               len_in = '0;
               ovf_in = 1'b0;
            end else begin
               cmd.kind = (char_byte == CH_NL) ? CMD_NL : CMD_CHAR;
            end
         end
         MODE_READ:  cmd.kind = CMD_READ;
         MODE_CLEAR: cmd.kind = CMD_CLEAR;
         MODE_CURSOR: begin
            cmd.kind = CMD_SETCUR;
            cmd.col  = (32'(new_col) > COLUMNS - 1) ? COL_W'(COLUMNS - 1)
                                                    : COL_W'(new_col);
            cmd.row  = (32'(new_row) > ROWS - 1) ? ROW_W'(ROWS - 1)
                                                 : ROW_W'(new_row);
         end
         default: cmd.kind = CMD_NOP;
      endcase
      cmd.color = color_in;
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff <= GREY;
         esc_ff   <= 1'b0;
         lit_ff   <= 1'b0;
         len_ff   <= '0;
         ovf_ff   <= 1'b0;
      end else if (req_fire) begin
         color_ff <= color_in;
         esc_ff   <= esc_in;
         lit_ff   <= lit_in;
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
      end
   end

   // name buffer, no reset
   always_ff @(posedge clock) begin
      if (req_fire && store) begin
         name_ff[len_ff[NI_W-1:0]] <= char_byte;
      end
   end

endmodule

FILE: src/tcw_queue.sv
// ----------------------------------------------------------------------------
// tcw_queue: command queue
// Short FIFO of classified commands between front and back.
// ----------------------------------------------------------------------------
module tcw_queue import tcw_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    full,
   output logic    empty
);

   cmd_type          q_ff [QDEPTH];
   logic [QP_W-1:0]  wp_ff, rp_ff;
   logic [QC_W-1:0]  cnt_ff;

   assign full  = (32'(cnt_ff) == QDEPTH);
   assign empty = (cnt_ff == '0);
   assign head  = q_ff[rp_ff];

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= (32'(wp_ff) == QDEPTH - 1) ? '0 : wp_ff + 1'b1;
         end
         if (pop) begin
            rp_ff <= (32'(rp_ff) == QDEPTH - 1) ? '0 : rp_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= push_cmd;
      end
   end

endmodule

FILE: src/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back: command executor
// Owns the cursor and the screen RAM ports; writes, reads, clears, scrolls.
// ----------------------------------------------------------------------------
module tcw_back import tcw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             head,
   input  logic                q_empty,
   output logic                pop,
   output logic                ram_we,
   output logic [AW-1:0]       ram_waddr,
   output logic [DATA_W-1:0]   ram_wdata,
   output logic [AW-1:0]       ram_raddr,
   input  logic [DATA_W-1:0]   ram_rdata,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [DATA_W-1:0]   rsp_read_data,
   output logic [PCOL_W-1:0]   rsp_cursor_col,
   output logic [PROW_W-1:0]   rsp_cursor_row,
   output logic                rsp_scrolled,
   output logic [CLR_W-1:0]    rsp_color
);

   typedef enum logic [2:0] {
      ST_INIT, ST_IDLE, ST_READ, ST_STEP, ST_SCROLL, ST_CLEAR
   } state_type;

   state_type          state_ff, state_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [SW-1:0]      sweep_ff, sweep_in;
   logic [1:0]         adv_ff, adv_in;
   logic               scr_ff, scr_in;
   logic [CLR_W-1:0]   hold_ff, hold_in;
   logic               vld_ff, vld_in;
   logic [DATA_W-1:0]  rd_ff, rd_in;
   logic [PCOL_W-1:0]  ocol_ff, ocol_in;
   logic [PROW_W-1:0]  orow_ff, orow_in;
   logic               oscr_ff, oscr_in;
   logic [CLR_W-1:0]   oclr_ff, oclr_in;

   logic               out_free;
   logic               load;
   logic [DATA_W-1:0]  load_rd;
   logic               wrap;
   logic [SW-1:0]      wr_idx;
   logic [SW-1:0]      rd_idx;
   logic [AW-1:0]      cur_addr;

   assign out_free = !vld_ff || rsp_tready;
   assign wrap     = (32'(col_ff) == COLUMNS - 1);
   assign wr_idx   = sweep_ff - 1'b1;
   assign rd_idx   = sweep_ff + SW'(COLUMNS);
   assign cur_addr = AW'(row_ff) * AW'(COLUMNS) + AW'(col_ff);

   // next state
   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      sweep_in  = sweep_ff;
      adv_in    = adv_ff;
      scr_in    = scr_ff;
      hold_in   = hold_ff;
      vld_in    = vld_ff && !rsp_tready;
      rd_in     = rd_ff;
      ocol_in   = ocol_ff;
      orow_in   = orow_ff;
      oscr_in   = oscr_ff;
      oclr_in   = oclr_ff;
      pop       = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = '0;
      ram_wdata = '0;
      ram_raddr = '0;
      load      = 1'b0;
      load_rd   = '0;

      unique case (state_ff)
         // reset fill of the whole screen
         ST_INIT: begin
            ram_we    = 1'b1;
            ram_waddr = sweep_ff[AW-1:0];
            ram_wdata = FILL_CELL;
            if (32'(sweep_ff) == CELLS - 1) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (!q_empty && out_free) begin
               pop     = 1'b1;
               hold_in = head.color;
               scr_in  = 1'b0;
               case (head.kind)
                  CMD_SETCUR: begin
                     row_in = head.row;
                     col_in = head.col;
                     load   = 1'b1;
                  end
                  CMD_READ: begin
                     if (32'(head.addr) < CELLS) begin
                        ram_raddr = head.addr[AW-1:0];
                        state_in  = ST_READ;
                     end else begin
                        load = 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     sweep_in = '0;
                     state_in = ST_CLEAR;
                  end
                  CMD_CHAR, CMD_NL: begin
                     if (head.kind == CMD_CHAR) begin
                        ram_we    = 1'b1;
                        ram_waddr = cur_addr;
                        ram_wdata = {4'b0, head.color, head.char_byte};
                     end
                     col_in = (wrap || head.kind == CMD_NL) ? '0 : col_ff + 1'b1;
                     adv_in = {1'b0, wrap} + {1'b0, head.kind == CMD_NL};
                     if (!wrap && head.kind != CMD_NL) begin
                        load = 1'b1;
                     end else begin
                        state_in = ST_STEP;
                     end
                  end
                  default: load = 1'b1;
               endcase
            end
         end
         ST_READ: begin
            load     = 1'b1;
            load_rd  = ram_rdata;
            state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = sweep_ff[AW-1:0];
            ram_wdata = '0;
            if (32'(sweep_ff) == CELLS - 1) begin
               sweep_in = '0;
               load     = 1'b1;
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         // one row advance per visit, scrolling at the bottom
         ST_STEP: begin
            if (adv_ff == '0) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end else if (32'(row_ff) == ROWS - 1) begin
               sweep_in = '0;
               state_in = ST_SCROLL;
            end else begin
               row_in = row_ff + 1'b1;
               adv_in = adv_ff - 1'b1;
            end
         end
         // copy each cell from one row below, read the cycle before it is written; last row zeroed
         ST_SCROLL: begin
            if (32'(sweep_ff) < CELLS - COLUMNS) begin
               ram_raddr = rd_idx[AW-1:0];
            end
            if (sweep_ff != '0) begin
               ram_we    = 1'b1;
               ram_waddr = wr_idx[AW-1:0];
               ram_wdata = (32'(wr_idx) < CELLS - COLUMNS) ? ram_rdata : '0;
            end
            if (32'(sweep_ff) == CELLS) begin
               sweep_in = '0;
               adv_in   = adv_ff - 1'b1;
               scr_in   = 1'b1;
               state_in = ST_STEP;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // result register load
      if (load) begin
         vld_in  = 1'b1;
         rd_in   = load_rd;
         ocol_in = PCOL_W'(col_in);
         orow_in = PROW_W'(row_in);
         oscr_in = scr_in;
         oclr_in = hold_in;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         row_ff   <= '0;
         col_ff   <= '0;
         sweep_ff <= '0;
         adv_ff   <= '0;
         scr_ff   <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         sweep_ff <= sweep_in;
         adv_ff   <= adv_in;
         scr_ff   <= scr_in;
         vld_ff   <= vld_in;
      end
      hold_ff <= hold_in;
      rd_ff   <= rd_in;
      ocol_ff <= ocol_in;
      orow_ff <= orow_in;
      oscr_ff <= oscr_in;
      oclr_ff <= oclr_in;
   end

   assign rsp_tvalid     = vld_ff;
   assign rsp_read_data  = rd_ff;
   assign rsp_cursor_col = ocol_ff;
   assign rsp_cursor_row = orow_ff;
   assign rsp_scrolled   = oscr_ff;
   assign rsp_color      = oclr_ff;

endmodule
